### rtl/lpc_pkg.sv
// lpc_pkg: shared types and constants of the lane polygon classifier
package lpc_pkg;

   localparam int COORD_W    = 16;
   localparam int COUNT_W    = 4;
   localparam int LANE_NUM_W = 4;
   localparam int LANES_W    = 4;
   localparam int LANE_ID_W  = 5;   // covers up to 32 lane cells
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic KIND_LOAD     = 1'b0;
   localparam logic KIND_CLASSIFY = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_LANES_IN_USE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_SCAN
   } state_type;

   // sign of one edge cross product, tagged with its lane
   typedef struct packed {
      logic                 valid;
      logic                 neg;
      logic                 pos;
      logic [LANE_ID_W-1:0] lane;
   } sign_type;

   // search token travelling down the lane cells
   typedef struct packed {
      logic                  tok;
      logic                  found;
      logic [LANE_NUM_W-1:0] num;
   } scan_type;

endpackage

### rtl/lpc_xprod.sv
// lpc_xprod: three-stage pipeline forming the sign of one edge cross product
module lpc_xprod (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [lpc_pkg::LANE_ID_W-1:0]       in_lane,
   input  logic signed [lpc_pkg::COORD_W-1:0]  x0,
   input  logic signed [lpc_pkg::COORD_W-1:0]  y0,
   input  logic signed [lpc_pkg::COORD_W-1:0]  x1,
   input  logic signed [lpc_pkg::COORD_W-1:0]  y1,
   input  logic signed [lpc_pkg::COORD_W-1:0]  px,
   input  logic signed [lpc_pkg::COORD_W-1:0]  py,
   output lpc_pkg::sign_type                   sign_out,
   output logic                                active
);

   localparam int DW = lpc_pkg::COORD_W + 1;
   localparam int PW = 2 * DW;

   logic                          v1_ff, v2_ff;
   logic [lpc_pkg::LANE_ID_W-1:0] lane1_ff, lane2_ff;
   logic signed [DW-1:0]          ex_ff, ey_ff, qx_ff, qy_ff;
   logic signed [DW-1:0]          ex_in, ey_in, qx_in, qy_in;
   logic signed [PW-1:0]          p1_ff, p2_ff, p1_in, p2_in;
   logic signed [PW:0]            cross_val;
   lpc_pkg::sign_type             sign_ff, sign_in;

   assign ex_in = DW'(x1) - DW'(x0);
   assign ey_in = DW'(y1) - DW'(y0);
   assign qx_in = DW'(px) - DW'(x0);
   assign qy_in = DW'(py) - DW'(y0);

   assign p1_in = PW'(ex_ff * qy_ff);
   assign p2_in = PW'(ey_ff * qx_ff);

   assign cross_val = (PW + 1)'(p1_ff) - (PW + 1)'(p2_ff);

   always_comb begin
      sign_in.valid = v2_ff;
      sign_in.lane  = lane2_ff;
      sign_in.neg   = cross_val[PW];
      sign_in.pos   = !cross_val[PW] && (cross_val != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         sign_ff.valid <= 1'b0;
      end else begin
         v1_ff         <= in_valid;
         v2_ff         <= v1_ff;
         sign_ff.valid <= sign_in.valid;
      end
      lane1_ff     <= in_lane;
      lane2_ff     <= lane1_ff;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      sign_ff.neg  <= sign_in.neg;
      sign_ff.pos  <= sign_in.pos;
      sign_ff.lane <= sign_in.lane;
   end

   assign sign_out = sign_ff;
   assign active   = v1_ff || v2_ff || sign_ff.valid;

endmodule

### rtl/lpc_lane_cell.sv
// lpc_lane_cell: one lane's vertex count, edge sign flags and search stage
module lpc_lane_cell #(
   parameter int LANE_ID = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              count_we,
   input  logic [lpc_pkg::COUNT_W-1:0]       count_wdata,
   input  logic                              flags_clear,
   input  lpc_pkg::sign_type                 sign_in,
   input  logic [lpc_pkg::LANES_W-1:0]       limit,
   input  lpc_pkg::scan_type                 scan_in,
   output lpc_pkg::scan_type                 scan_out,
   output logic [lpc_pkg::COUNT_W-1:0]       count
);

   logic [lpc_pkg::COUNT_W-1:0]    count_ff;
   logic                           nonneg_ff, nonpos_ff;
   logic                           tok_ff, found_ff, found_in;
   logic [lpc_pkg::LANE_NUM_W-1:0] num_ff, num_in;
   logic                           mine, hit;

   assign mine = sign_in.valid && (sign_in.lane == lpc_pkg::LANE_ID_W'(LANE_ID));
   assign hit  = scan_in.tok && !scan_in.found && (32'(limit) > LANE_ID)
                 && (nonneg_ff || nonpos_ff);

   always_comb begin
      if (hit) begin
         found_in = 1'b1;
         num_in   = lpc_pkg::LANE_NUM_W'(LANE_ID + 1);
      end else begin
         found_in = scan_in.found;
         num_in   = scan_in.num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tok_ff   <= 1'b0;
      end else begin
         tok_ff <= scan_in.tok;
         if (count_we) begin
            count_ff <= count_wdata;
         end
      end
   end

   // flags start true per request and fall with each opposing edge sign
   always_ff @(posedge clock) begin
      found_ff <= found_in;
      num_ff   <= num_in;
      if (flags_clear) begin
         nonneg_ff <= 1'b1;
         nonpos_ff <= 1'b1;
      end else if (mine) begin
         nonneg_ff <= nonneg_ff && !sign_in.neg;
         nonpos_ff <= nonpos_ff && !sign_in.pos;
      end
   end

   assign scan_out.tok   = tok_ff;
   assign scan_out.found = found_ff;
   assign scan_out.num   = num_ff;
   assign count          = count_ff;

endmodule

### rtl/lane_polygon_classifier_unit.sv
// lane_polygon_classifier_unit: top level, vertex store, edge walker and lane cell row
// load request: written straight into the vertex store, busy stays low, no result
// classify request: the edge walk, the drain of the pipeline and the sign search run in turn,
// then the result strobes; a new request can be accepted in the cycle after the result
// the walker reads one edge per cycle from the two-port vertex store while its lane is not
// empty; the sign search then passes down the lane cells, one cell per cycle
// reset clears lanes_in_use and all vertex counts; the vertex store is not cleared
module lane_polygon_classifier_unit #(
   parameter int MAX_LANES    = 8,
   parameter int MAX_VERTICES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_kind,
   input  logic [2:0]                           req_lane_index,
   input  logic [2:0]                           req_vertex_index,
   input  logic                                 req_final_vertex,
   input  logic signed [lpc_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [lpc_pkg::COORD_W-1:0]   req_coord_y,
   output logic                                 rsp_valid,
   output logic [lpc_pkg::LANE_NUM_W-1:0]       rsp_lane_number,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lpc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [lpc_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [lpc_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   localparam int DEPTH = MAX_LANES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam int LCW   = $clog2(MAX_LANES + 1);
   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int WW    = 2 * lpc_pkg::COORD_W;

   lpc_pkg::state_type state_ff, state_in;

   logic [lpc_pkg::LANES_W-1:0] lanes_in_use_ff;
   logic [lpc_pkg::LANES_W-1:0] limit_ff, limit_in;
   logic [LCW-1:0]              lane_ff, lane_in;
   logic [LW-1:0]               lane_idx;
   logic [VW-1:0]               j_ff, j_in;
   logic [VW-1:0]               k_sel;
   logic signed [lpc_pkg::COORD_W-1:0] pt_x_ff, pt_y_ff;

   logic                        req_fire, classify_fire, load_fire, csr_write;
   logic                        lane_done, edge_last, issue, scan_start, active;
   logic [lpc_pkg::COUNT_W-1:0] cur_n;
   logic [AW-1:0]               waddr, addr_j, addr_k;

   logic [WW-1:0]               mem [DEPTH];
   logic [WW-1:0]               rd_j_ff, rd_k_ff;
   logic                        rd_valid_ff;
   logic [lpc_pkg::LANE_ID_W-1:0] rd_lane_ff;

   logic [lpc_pkg::COUNT_W-1:0] cell_count [MAX_LANES];
   lpc_pkg::scan_type           scan_chain [MAX_LANES + 1];
   lpc_pkg::sign_type           edge_sign;
   logic                        xprod_active;

   assign busy          = (state_ff != lpc_pkg::ST_IDLE);
   assign req_fire      = start && !busy;
   assign classify_fire = req_fire && (req_kind == lpc_pkg::KIND_CLASSIFY);
   assign load_fire     = req_fire && (req_kind == lpc_pkg::KIND_LOAD)
                          && (32'(req_lane_index) < MAX_LANES)
                          && (32'(req_vertex_index) < MAX_VERTICES);
   assign waddr = AW'(32'(req_lane_index) * MAX_VERTICES + 32'(req_vertex_index));

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == lpc_pkg::REG_LANES_IN_USE)
                      ? lpc_pkg::CSR_DATA_W'(lanes_in_use_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_in_use_ff <= '0;
      end else if (csr_write && (paddr[2] == lpc_pkg::REG_LANES_IN_USE)) begin
         lanes_in_use_ff <= pwdata[lpc_pkg::LANES_W-1:0];
      end
   end

   // lanes beyond the cell row are never tested
   assign limit_in = (32'(lanes_in_use_ff) > MAX_LANES)
                     ? lpc_pkg::LANES_W'(MAX_LANES) : lanes_in_use_ff;

   // edge walker
   assign lane_idx  = lane_ff[LW-1:0];
   assign cur_n     = cell_count[lane_idx];
   assign lane_done = (32'(lane_ff) >= 32'(limit_ff));
   assign edge_last = ((32'(j_ff) + 1) == 32'(cur_n));
   assign k_sel     = edge_last ? '0 : (j_ff + VW'(1));
   assign addr_j    = AW'(32'(lane_idx) * MAX_VERTICES + 32'(j_ff));
   assign addr_k    = AW'(32'(lane_idx) * MAX_VERTICES + 32'(k_sel));
   assign active    = rd_valid_ff || xprod_active;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpc_pkg::ST_IDLE: begin
            if (classify_fire) begin
               state_in = lpc_pkg::ST_WALK;
            end
         end
         lpc_pkg::ST_WALK: begin
            if (lane_done) begin
               state_in = lpc_pkg::ST_DRAIN;
            end
         end
         lpc_pkg::ST_DRAIN: begin
            if (!active) begin
               state_in = lpc_pkg::ST_SCAN;
            end
         end
         lpc_pkg::ST_SCAN: begin
            if (scan_chain[MAX_LANES].tok) begin
               state_in = lpc_pkg::ST_IDLE;
            end
         end
         default: state_in = lpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      issue      = 1'b0;
      scan_start = 1'b0;
      lane_in    = lane_ff;
      j_in       = j_ff;
      unique case (state_ff)
         lpc_pkg::ST_IDLE: begin
            lane_in = '0;
            j_in    = '0;
         end
         lpc_pkg::ST_WALK: begin
            if (!lane_done) begin
               if (cur_n == '0) begin
                  // empty lane has no edges
                  lane_in = lane_ff + LCW'(1);
                  j_in    = '0;
               end else begin
                  issue = 1'b1;
                  if (edge_last) begin
                     lane_in = lane_ff + LCW'(1);
                     j_in    = '0;
                  end else begin
                     j_in = j_ff + VW'(1);
                  end
               end
            end
         end
         lpc_pkg::ST_DRAIN: begin
            scan_start = !active;
         end
         lpc_pkg::ST_SCAN: begin
            scan_start = 1'b0;
         end
         default: begin
            lane_in = '0;
            j_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lpc_pkg::ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff    <= lane_in;
      j_ff       <= j_in;
      rd_lane_ff <= lpc_pkg::LANE_ID_W'(lane_idx);
      if (classify_fire) begin
         limit_ff <= limit_in;
         pt_x_ff  <= req_coord_x;
         pt_y_ff  <= req_coord_y;
      end
   end

   // vertex store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (load_fire) begin
         mem[waddr] <= {req_coord_x, req_coord_y};
      end
      rd_j_ff <= mem[addr_j];
      rd_k_ff <= mem[addr_k];
   end

   lpc_xprod u_xprod (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .in_lane  (rd_lane_ff),
      .x0       (signed'(rd_j_ff[WW-1:lpc_pkg::COORD_W])),
      .y0       (signed'(rd_j_ff[lpc_pkg::COORD_W-1:0])),
      .x1       (signed'(rd_k_ff[WW-1:lpc_pkg::COORD_W])),
      .y1       (signed'(rd_k_ff[lpc_pkg::COORD_W-1:0])),
      .px       (pt_x_ff),
      .py       (pt_y_ff),
      .sign_out (edge_sign),
      .active   (xprod_active)
   );

   assign scan_chain[0] = {scan_start, 1'b0, lpc_pkg::LANE_NUM_W'(0)};

   for (genvar i = 0; i < MAX_LANES; i++) begin : g_cell
      lpc_lane_cell #(
         .LANE_ID (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .count_we    (load_fire && req_final_vertex && (32'(req_lane_index) == i)),
         .count_wdata (lpc_pkg::COUNT_W'(req_vertex_index) + lpc_pkg::COUNT_W'(1)),
         .flags_clear (classify_fire),
         .sign_in     (edge_sign),
         .limit       (limit_ff),
         .scan_in     (scan_chain[i]),
         .scan_out    (scan_chain[i+1]),
         .count       (cell_count[i])
      );
   end

   assign rsp_valid       = scan_chain[MAX_LANES].tok;
   assign rsp_lane_number = scan_chain[MAX_LANES].found ? scan_chain[MAX_LANES].num : '0;

endmodule

### rtl/lpc_checker.sv
// lpc_checker: port-level assertions for the lane polygon classifier, with its bind
module lpc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_kind,
   input logic rsp_valid
);

   // one result per classify request, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a result only appears while a classify request is in flight
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // the block frees up right after delivering its result
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("still busy after result");

   // a classify request occupies the block
   a_classify_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == lpc_pkg::KIND_CLASSIFY)) |=> busy)
      else $error("classify request did not raise busy");

   // a load request finishes in its own cycle
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == lpc_pkg::KIND_LOAD)) |=> !busy)
      else $error("load request raised busy");

endmodule

bind lane_polygon_classifier_unit lpc_checker u_lpc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid)
);
